>>> src/sbc_pkg.sv
// Shared constants, types and the lane control bundle for the sensor bias calibrator.
// No dependencies; every other file of the block depends on this package.
package sbc_pkg;

	// Number of axis fields carried by one word, and the defaults handed to the top level.
	localparam int NUM_FIELDS      = 3;
	localparam int AXES_DEF        = 3;
	localparam int SAMPLE_BITS_DEF = 16;

	// The sample count register and the taken counter are fixed at 16 bits.
	localparam int              CNT_BITS         = 16;
	localparam logic [CNT_BITS-1:0] SAMPLE_COUNT_RST = 16'd1000;

	// Sequencer states.
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV
	} sbc_state_t;

	// Control bundle from the sequencer to every lane.
	typedef struct packed {
		logic clear;     // drop sums and biases
		logic capture;   // latch the incoming sample
		logic acc;       // add the latched sample to the sum
		logic sub;       // result is sample minus bias
		logic div_load;  // load the divider with the sum magnitude
		logic div_step;  // one restoring division step
		logic div_fin;   // write the quotient into the bias
	} lane_ctl_t;

endpackage

>>> src/sbc_in_if.sv
// Input channel of the sensor bias calibrator: one raw three-axis word per handshake.
// Depends on sbc_pkg for the default sample width.
interface sbc_in_if #(
	parameter int SAMPLE_BITS = sbc_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] axis_x;
	logic signed [SAMPLE_BITS-1:0] axis_y;
	logic signed [SAMPLE_BITS-1:0] axis_z;

	modport source (output valid, output axis_x, output axis_y, output axis_z, input ready);
	modport sink (input valid, input axis_x, input axis_y, input axis_z, output ready);
endinterface

>>> src/sbc_out_if.sv
// Output channel of the sensor bias calibrator: one corrected word per handshake.
// Depends on sbc_pkg for the default sample width.
interface sbc_out_if #(
	parameter int SAMPLE_BITS = sbc_pkg::SAMPLE_BITS_DEF
);
	logic                        valid;
	logic                        ready;
	logic                        applied;
	logic signed [SAMPLE_BITS:0] out_x;
	logic signed [SAMPLE_BITS:0] out_y;
	logic signed [SAMPLE_BITS:0] out_z;

	modport source (output valid, output applied, output out_x, output out_y, output out_z,
		input ready);
	modport sink (input valid, input applied, input out_x, input out_y, input out_z,
		output ready);
endinterface

>>> src/sbc_cfg_if.sv
// Configuration write channel of the sensor bias calibrator: carries the sample count.
// Depends on sbc_pkg for the counter width.
interface sbc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [sbc_pkg::CNT_BITS-1:0]  sample_count;

	modport source (output valid, output sample_count, input ready);
	modport sink (input valid, input sample_count, output ready);
endinterface

>>> src/sbc_lane.sv
// One axis lane: running sum, serial restoring divider for the bias, and bias removal.
// Depends on sbc_pkg for the control bundle and the counter width.
module sbc_lane #(
	parameter int SAMPLE_BITS = sbc_pkg::SAMPLE_BITS_DEF,
	parameter int SUM_BITS    = sbc_pkg::SAMPLE_BITS_DEF + sbc_pkg::CNT_BITS,
	parameter bit ACTIVE      = 1'b1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  sbc_pkg::lane_ctl_t                 ctl,
	input  logic [sbc_pkg::CNT_BITS-1:0]       divisor,
	input  logic signed [SAMPLE_BITS-1:0]      sample,
	output logic signed [SAMPLE_BITS:0]        result
);
	import sbc_pkg::*;

	logic signed [SAMPLE_BITS-1:0] smp_s1;
	logic signed [SUM_BITS-1:0]    sum_q;
	logic signed [SAMPLE_BITS-1:0] bias_q;
	logic [SUM_BITS-1:0]           dvd_q;
	logic [CNT_BITS-1:0]           rem_q;
	logic                          neg_q;

	logic [CNT_BITS:0]             rem_sh;
	logic                          rem_ge;
	logic [CNT_BITS:0]             rem_nx;
	logic [SUM_BITS-1:0]           sum_mag;
	logic [SAMPLE_BITS-1:0]        quot;

	// Restoring division step: shift one dividend bit into the remainder.
	always_comb begin
		rem_sh  = {rem_q, dvd_q[SUM_BITS-1]};
		rem_ge  = (rem_sh >= {1'b0, divisor});
		rem_nx  = rem_ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
		sum_mag = sum_q[SUM_BITS-1] ? SUM_BITS'(-sum_q) : SUM_BITS'(sum_q);
		quot    = dvd_q[SAMPLE_BITS-1:0];
	end

	// Sample capture.
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			smp_s1 <= sample;
		end
	end

	// Running sum and bias; inactive lanes keep both at zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			bias_q <= '0;
		end else if (ctl.clear) begin
			sum_q  <= '0;
			bias_q <= '0;
		end else if (ACTIVE) begin
			if (ctl.acc) begin
				sum_q <= sum_q + SUM_BITS'(smp_s1);
			end
			if (ctl.div_fin) begin
				bias_q <= neg_q ? SAMPLE_BITS'(-quot) : SAMPLE_BITS'(quot);
			end
		end
	end

	// Divider registers: the dividend shifts out as the quotient shifts in.
	always_ff @(posedge clk) begin
		if (ctl.div_load) begin
			dvd_q <= sum_mag;
			rem_q <= '0;
			neg_q <= sum_q[SUM_BITS-1];
		end else if (ctl.div_step) begin
			dvd_q <= {dvd_q[SUM_BITS-2:0], rem_ge};
			rem_q <= rem_nx[CNT_BITS-1:0];
		end
	end

	// Pass the raw sample while calibrating, remove the bias afterwards.
	always_comb begin
		if (ctl.sub) begin
			result = (SAMPLE_BITS+1)'(smp_s1) - (SAMPLE_BITS+1)'(bias_q);
		end else begin
			result = (SAMPLE_BITS+1)'(smp_s1);
		end
	end

endmodule

>>> src/sensor_bias_calibrator.sv
// Sensor bias calibrator top level: sequencer, three axis lanes and the output register.
// Depends on sbc_pkg, the three channel interfaces and sbc_lane.
//
// Usage: raw three-axis words enter on the samples channel, corrected words leave on
// the results channel, and the cfg channel writes the sample count. Each accepted word
// gives exactly one result word. For the first sample_count words after reset or a
// count write, the lanes accumulate per-axis sums and the word passes unchanged with
// applied low. When the last of those words has been summed, each lane divides its sum
// by the count in a serial restoring divider, one quotient bit per cycle. Every later
// word has the per-axis bias subtracted and leaves with applied high.
// A word is accepted into the execute state, which loads its result into the output
// register once the register is free; no new word is taken until the execute state is
// left, and the word that completes calibration holds the input further while the
// dividers run in the divide state. A pending count write takes precedence over a word.
// Reset loads a count of 1000 and clears sums and biases. The output register holds a
// result until it is taken; while the receiver stalls, one more word is accepted and
// then waits in the lanes until the output register frees up.
module sensor_bias_calibrator #(
	parameter int AXES        = sbc_pkg::AXES_DEF,
	parameter int SAMPLE_BITS = sbc_pkg::SAMPLE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sbc_in_if.sink     samples,
	sbc_out_if.source  results,
	sbc_cfg_if.sink    cfg
);
	import sbc_pkg::*;

	localparam int SUM_BITS = SAMPLE_BITS + CNT_BITS;
	localparam int DCW      = $clog2(SUM_BITS + 2);
	localparam logic [DCW-1:0] DIV_LAST = DCW'(SUM_BITS + 1);

	sbc_state_t                state_q, state_nx;
	logic [CNT_BITS-1:0]       sample_count_q;
	logic [CNT_BITS-1:0]       taken_q;
	logic [DCW-1:0]            div_cnt_q;
	lane_ctl_t                 ctl;

	logic                      calibrating;
	logic                      slot_free;
	logic                      out_load;
	logic                      cfg_wr;
	logic [CNT_BITS-1:0]       taken_inc;

	logic                      out_valid_q;
	logic                      applied_q;
	logic signed [SAMPLE_BITS:0] out_q [NUM_FIELDS];

	logic signed [SAMPLE_BITS-1:0] lane_in  [NUM_FIELDS];
	logic signed [SAMPLE_BITS:0]   lane_out [NUM_FIELDS];

	assign lane_in[0] = samples.axis_x;
	assign lane_in[1] = samples.axis_y;
	assign lane_in[2] = samples.axis_z;

	assign calibrating = (taken_q != sample_count_q);
	assign slot_free   = !out_valid_q || results.ready;
	assign cfg_wr      = cfg.valid && cfg.ready;
	assign taken_inc   = taken_q + CNT_BITS'(1);

	// A word is only taken in idle cycles without a count write.
	assign cfg.ready     = (state_q == ST_IDLE);
	assign samples.ready = (state_q == ST_IDLE) && !cfg.valid;

	// Sequencer: next state and lane controls.
	always_comb begin
		state_nx     = state_q;
		ctl          = '0;
		out_load     = 1'b0;
		ctl.clear    = cfg_wr;
		ctl.sub      = !calibrating;
		unique case (state_q)
			ST_IDLE: begin
				if (samples.valid && !cfg_wr) begin
					ctl.capture = 1'b1;
					state_nx    = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (slot_free) begin
					out_load = 1'b1;
					ctl.acc  = calibrating;
					if (calibrating && (taken_inc == sample_count_q)) begin
						state_nx = ST_DIV;
					end else begin
						state_nx = ST_IDLE;
					end
				end
			end
			ST_DIV: begin
				ctl.div_load = (div_cnt_q == '0);
				ctl.div_step = (div_cnt_q != '0) && (div_cnt_q != DIV_LAST);
				ctl.div_fin  = (div_cnt_q == DIV_LAST);
				if (div_cnt_q == DIV_LAST) begin
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// Count register, taken counter and divider step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= SAMPLE_COUNT_RST;
			taken_q        <= '0;
			div_cnt_q      <= '0;
		end else begin
			if (cfg_wr) begin
				sample_count_q <= cfg.sample_count;
				taken_q        <= '0;
			end else if (ctl.acc) begin
				taken_q <= taken_inc;
			end
			if (state_q == ST_DIV) begin
				div_cnt_q <= ctl.div_fin ? '0 : div_cnt_q + DCW'(1);
			end else begin
				div_cnt_q <= '0;
			end
		end
	end

	// Axis lanes; lanes at or beyond AXES never sum and keep a zero bias.
	for (genvar i = 0; i < NUM_FIELDS; i++) begin : g_lane
		sbc_lane #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.SUM_BITS    (SUM_BITS),
			.ACTIVE      (i < AXES)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.divisor (sample_count_q),
			.sample  (lane_in[i]),
			.result  (lane_out[i])
		);
	end

	// Output register merges the lane results into one word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			applied_q <= !calibrating;
			for (int i = 0; i < NUM_FIELDS; i++) begin
				out_q[i] <= lane_out[i];
			end
		end
	end

	assign results.valid   = out_valid_q;
	assign results.applied = applied_q;
	assign results.out_x   = out_q[0];
	assign results.out_y   = out_q[1];
	assign results.out_z   = out_q[2];

`ifndef SYNTH
	// The taken counter never runs past the programmed count.
	a_taken_bound: assert property (@(posedge clk) disable iff (!arst_n)
		taken_q <= sample_count_q)
		else $error("taken counter exceeds sample count");

	// The divider only runs once calibration is complete.
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (taken_q == sample_count_q))
		else $error("divider running before calibration completed");

	// An accepted word is always followed by the execute state.
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready && !cfg_wr) |=> (state_q == ST_EXEC))
		else $error("accepted word not executed");

	// After the final divider step writes the bias, the block returns to idle.
	a_div_exit: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.div_fin |=> (state_q == ST_IDLE))
		else $error("sequencer did not return to idle after division");
`endif

endmodule
